[hw/rtl/spq_pkg.sv]
// spq_pkg: shared types, codes and sizes for the sorted priority queue
// depends on nothing; imported by spq_ctrl, spq_datapath and sorted_priority_queue

package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int PRI_W         = 16;
    localparam int PAY_W         = 32;
    localparam int ERR_W         = 2;
    localparam int COUNT_W       = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2
    } err_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;   // capture the accepted input beat
        logic commit;    // apply the operation and load the result register
    } spq_cmd_t;

endpackage

[hw/rtl/spq_ctrl.sv]
// spq_ctrl: controller state machine for the sorted priority queue
// depends on spq_pkg; drives spq_datapath through spq_cmd_t

module spq_ctrl
    import spq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output spq_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // result register can take a new beat
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd.load_in  = 1'b0;
        cmd.commit   = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[hw/rtl/spq_datapath.sv]
// spq_datapath: sorted entry row, occupancy counter and result register
// depends on spq_pkg; commanded by spq_ctrl

module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  spq_cmd_t                 cmd,
    input  logic                     in_op,
    input  logic        [PRI_W-1:0]  in_priority,
    input  logic signed [PAY_W-1:0]  in_payload,
    output logic        [PRI_W-1:0]  head_priority,
    output logic signed [PAY_W-1:0]  head_payload,
    output logic                     empty_res,
    output logic                     full_res,
    output logic        [ERR_W-1:0]  error,
    output logic        [COUNT_W-1:0] count
);

    localparam int OCC_W = $clog2(DEPTH + 1);

    // captured input beat
    logic               op_reg;
    logic [PRI_W-1:0]   pri_reg;
    logic [PAY_W-1:0]   pay_reg;

    // sorted row, slot 0 is the head
    logic [PRI_W-1:0]   ent_pri_reg  [DEPTH];
    logic [PAY_W-1:0]   ent_pay_reg  [DEPTH];
    logic [PRI_W-1:0]   ent_pri_next [DEPTH];
    logic [PAY_W-1:0]   ent_pay_next [DEPTH];
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [DEPTH-1:0]   keep;
    logic               is_full, is_empty;
    err_t               err_next;

    // result register
    logic [PRI_W-1:0]   head_pri_reg;
    logic [PAY_W-1:0]   head_pay_reg;
    logic               empty_reg, full_reg;
    err_t               err_reg;
    logic [OCC_W-1:0]   cnt_reg;
    logic [COUNT_W+OCC_W-1:0] cnt_ext;

    assign is_full  = (occ_reg == OCC_W'(DEPTH));
    assign is_empty = (occ_reg == '0);

    // slot keeps its entry when it is occupied and not below the new priority
    for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
        assign keep[i] = (occ_reg > OCC_W'(i)) && (ent_pri_reg[i] >= pri_reg);
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_slot
        always_comb begin
            ent_pri_next[i] = ent_pri_reg[i];
            ent_pay_next[i] = ent_pay_reg[i];
            if (op_reg == OP_INSERT) begin
                if (!is_full && !keep[i]) begin
                    if (i == 0) begin
                        ent_pri_next[i] = pri_reg;
                        ent_pay_next[i] = pay_reg;
                    end else if (keep[(i == 0) ? 0 : i-1]) begin
                        ent_pri_next[i] = pri_reg;
                        ent_pay_next[i] = pay_reg;
                    end else begin
                        ent_pri_next[i] = ent_pri_reg[(i == 0) ? 0 : i-1];
                        ent_pay_next[i] = ent_pay_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end else begin
                if (!is_empty && (i < DEPTH-1)) begin
                    ent_pri_next[i] = ent_pri_reg[(i < DEPTH-1) ? i+1 : i];
                    ent_pay_next[i] = ent_pay_reg[(i < DEPTH-1) ? i+1 : i];
                end
            end
        end
    end

    always_comb begin
        occ_next = occ_reg;
        err_next = ERR_OK;
        if (op_reg == OP_INSERT) begin
            if (is_full) begin
                err_next = ERR_OVERFLOW;
            end else begin
                occ_next = occ_reg + OCC_W'(1);
            end
        end else begin
            if (is_empty) begin
                err_next = ERR_UNDERFLOW;
            end else begin
                occ_next = occ_reg - OCC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg  <= in_op;
            pri_reg <= in_priority;
            pay_reg <= in_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            for (int k = 0; k < DEPTH; k++) begin
                ent_pri_reg[k] <= ent_pri_next[k];
                ent_pay_reg[k] <= ent_pay_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (cmd.commit) begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            head_pri_reg <= (occ_next != '0) ? ent_pri_next[0] : '0;
            head_pay_reg <= (occ_next != '0) ? ent_pay_next[0] : '0;
            empty_reg    <= (occ_next == '0);
            full_reg     <= (occ_next == OCC_W'(DEPTH));
            err_reg      <= err_next;
            cnt_reg      <= occ_next;
        end
    end

    // count carries the low bits of the occupancy
    assign cnt_ext = {{COUNT_W{1'b0}}, cnt_reg};

    assign head_priority = head_pri_reg;
    assign head_payload  = head_pay_reg;
    assign empty_res     = empty_reg;
    assign full_res      = full_reg;
    assign error         = err_reg;
    assign count         = cnt_ext[COUNT_W-1:0];

endmodule

[hw/rtl/sorted_priority_queue.sv]
// sorted_priority_queue: top level of the sorted list priority queue
// depends on spq_pkg, spq_ctrl and spq_datapath
//
// channel  direction  handshake          payload
// s_       in         s_valid / s_ready  s_op, s_priority_req, s_payload
// m_       out        m_valid / m_ready  m_head_priority, m_head_payload, m_empty_res,
//                                        m_full_res, m_error, m_count
//
// each beat is first captured and then used to update the sorted row
// the update compares every slot against the new priority in parallel and shifts
// the row by one place, so the row register is the single work stage
// the result sits in an output register; a new beat is taken while it waits,
// and the update stalls only while the previous result has not been taken
// aresetn (synchronous) empties the queue; entry slots hold no reset value

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input beats
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_op,
    input  logic        [PRI_W-1:0]   s_priority_req,
    input  logic signed [PAY_W-1:0]   s_payload,
    // result beats
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic        [PRI_W-1:0]   m_head_priority,
    output logic signed [PAY_W-1:0]   m_head_payload,
    output logic                      m_empty_res,
    output logic                      m_full_res,
    output logic        [ERR_W-1:0]   m_error,
    output logic        [COUNT_W-1:0] m_count
);

    spq_cmd_t cmd;

    // sequencing: capture, then update and load result
    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // sorted row, occupancy and result register
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_op         (s_op),
        .in_priority   (s_priority_req),
        .in_payload    (s_payload),
        .head_priority (m_head_priority),
        .head_payload  (m_head_payload),
        .empty_res     (m_empty_res),
        .full_res      (m_full_res),
        .error         (m_error),
        .count         (m_count)
    );

`ifndef SYNTHESIS
    // an empty queue reports a zero head
    a_empty_head_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_res |-> (m_head_priority == '0) && (m_head_payload == '0))
        else $error("empty result with non-zero head");

    // underflow only ever reported on an empty queue
    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error == ERR_UNDERFLOW) |-> m_empty_res && !m_full_res)
        else $error("underflow reported on a non-empty queue");

    // overflow only ever reported on a full queue
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error == ERR_OVERFLOW) |-> m_full_res && !m_empty_res)
        else $error("overflow reported on a queue that is not full");

    // a result beat follows an accepted input beat when the result register is free at acceptance
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (!m_valid || m_ready) |=> ##1 m_valid)
        else $error("result beat missing after accepted input beat");
`endif

endmodule
